FILE: design/fled_pkg.sv
// Shared types, constants and register map of the frame level event detector.
package fled_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int MAX_FRAME_DEF = 256;
    localparam int QUEUE_DEPTH   = 4;

    localparam int SAMPLE_SCALE = 100000;
    localparam int SCALE_SHIFT  = 48;
    localparam logic [63:0] SCALE_RECIP_WIDE = (64'd1 << SCALE_SHIFT) / 64'(SAMPLE_SCALE);
    localparam logic [31:0] SCALE_RECIP = SCALE_RECIP_WIDE[31:0];
    localparam int QUOT_W = $clog2(64'h8000_0000 / 64'(SAMPLE_SCALE) + 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE         = 3'd0,
        REG_LOUD_HIGH      = 3'd1,
        REG_LOUD_LOW       = 3'd2,
        REG_ATTACK_FRAMES  = 3'd3,
        REG_RELEASE_FRAMES = 3'd4,
        REG_DURATION_BIAS  = 3'd5
    } fled_reg_t;

    typedef struct packed {
        logic               enable;
        logic [14:0]        loud_high;
        logic signed [15:0] loud_low;
        logic [7:0]         attack_frames;
        logic [7:0]         release_frames;
        logic [15:0]        duration_bias;
    } fled_cfg_t;

    localparam fled_cfg_t CFG_RESET = '{
        enable:         1'b1,
        loud_high:      15'd25,
        loud_low:       -16'sd25,
        attack_frames:  8'd1,
        release_frames: 8'd5,
        duration_bias:  16'd100
    };

    // Frame verdict handed from the classifier to the event tracker
    typedef struct packed {
        logic              loud;
        logic [TIME_W-1:0] time_ms;
    } fled_cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fled_q_stat_t;

endpackage

FILE: design/fled_if.sv
// Stream interfaces for the sample input and the event record output.
interface fled_audio_if import fled_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_frame;
    logic [TIME_W-1:0]          time_ms;

    modport source (output valid, sample, last_in_frame, time_ms, input ready);
    modport sink   (input valid, sample, last_in_frame, time_ms, output ready);
endinterface

interface fled_report_if import fled_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_start;
    logic [TIME_W-1:0] stamp_ms;
    logic [TIME_W-1:0] duration_ms;

    modport source (output valid, is_start, stamp_ms, duration_ms, input ready);
    modport sink   (input valid, is_start, stamp_ms, duration_ms, output ready);
endinterface

FILE: design/fled_front.sv
// Front end: scale, accumulate and classify frames, push verdicts to the queue.
module fled_front import fled_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  fled_cfg_t        cfg,
    fled_audio_if.sink       audio,
    output logic             push,
    output fled_cls_t        push_word,
    input  fled_q_stat_t     q_stat
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = $clog2(MAX_FRAME) + QUOT_W + 1;
    localparam int CMP_W = QUOT_W + CNT_W + 2;

    logic adv;

    logic abs_valid_reg, est_valid_reg, chk_valid_reg, quo_valid_reg;
    logic frm_valid_reg, thr_valid_reg, cls_valid_reg;
    logic abs_valid_next, est_valid_next, chk_valid_next, quo_valid_next;
    logic frm_valid_next, thr_valid_next, cls_valid_next;

    logic [SAMPLE_W-1:0] abs_mag_reg, est_mag_reg, chk_mag_reg;
    logic [SAMPLE_W-1:0] abs_mag_next;
    logic                abs_neg_reg, est_neg_reg, chk_neg_reg;
    logic                abs_last_reg, est_last_reg, chk_last_reg, quo_last_reg;
    logic [TIME_W-1:0]   abs_time_reg, est_time_reg, chk_time_reg, quo_time_reg;
    logic [TIME_W-1:0]   frm_time_reg, thr_time_reg;

    logic [63:0]         est_prod;
    logic [QUOT_W-1:0]   est_q_reg, chk_q_reg, est_q_next;
    logic [SAMPLE_W-1:0] chk_prod_reg, chk_prod_next;

    logic [SAMPLE_W-1:0]     quo_rem;
    logic [QUOT_W-1:0]       quo_mag;
    logic signed [SUM_W-1:0] quo_val_reg, quo_val_next;

    logic signed [SUM_W-1:0] acc_sum_reg, acc_sum_next, sum_add;
    logic [CNT_W-1:0]        acc_cnt_reg, acc_cnt_next, cnt_add;
    logic                    add_ok;
    logic signed [SUM_W-1:0] frm_sum_reg;
    logic [CNT_W-1:0]        frm_cnt_reg;

    logic signed [CMP_W-1:0] thr_sum_reg, thr_hi_reg, thr_lo_reg;
    logic signed [CMP_W-1:0] thr_sum_next, thr_hi_next, thr_lo_next;

    fled_cls_t cls_word_reg, cls_word_next;

    // Hold the whole front while a verdict waits on a full queue
    assign adv         = !(cls_valid_reg && q_stat.full);
    assign audio.ready = adv;
    assign push        = cls_valid_reg && !q_stat.full;
    assign push_word   = cls_word_reg;

    always_comb
    begin
        abs_valid_next = audio.valid && cfg.enable;
        est_valid_next = abs_valid_reg;
        chk_valid_next = est_valid_reg;
        quo_valid_next = chk_valid_reg;
        frm_valid_next = quo_valid_reg && quo_last_reg;
        thr_valid_next = frm_valid_reg;
        cls_valid_next = thr_valid_reg;

        abs_mag_next = audio.sample[SAMPLE_W-1] ? (~audio.sample + 32'd1) : audio.sample;

        est_prod   = 64'(abs_mag_reg) * 64'(SCALE_RECIP);
        est_q_next = est_prod[SCALE_SHIFT +: QUOT_W];

        chk_prod_next = SAMPLE_W'(est_q_reg) * SAMPLE_W'(SAMPLE_SCALE);

        quo_rem  = chk_mag_reg - chk_prod_reg;
        quo_mag  = chk_q_reg + QUOT_W'(quo_rem >= SAMPLE_W'(SAMPLE_SCALE));
        quo_val_next = SUM_W'(quo_mag);
        if (chk_neg_reg)
        begin
            quo_val_next = -quo_val_next;
        end

        add_ok  = acc_cnt_reg < CNT_W'(MAX_FRAME);
        sum_add = acc_sum_reg + (add_ok ? quo_val_reg : '0);
        cnt_add = acc_cnt_reg + CNT_W'(add_ok);
        acc_sum_next = acc_sum_reg;
        acc_cnt_next = acc_cnt_reg;
        if (quo_valid_reg)
        begin
            acc_sum_next = quo_last_reg ? '0 : sum_add;
            acc_cnt_next = quo_last_reg ? '0 : cnt_add;
        end

        thr_sum_next = CMP_W'(frm_sum_reg);
        thr_hi_next  = CMP_W'(cfg.loud_high) * CMP_W'(frm_cnt_reg);
        thr_lo_next  = CMP_W'(cfg.loud_low) * $signed(CMP_W'(frm_cnt_reg));

        cls_word_next.loud    = (thr_sum_reg >= thr_hi_reg) || (thr_sum_reg <= thr_lo_reg);
        cls_word_next.time_ms = thr_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_valid_reg <= 1'b0;
            est_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            quo_valid_reg <= 1'b0;
            frm_valid_reg <= 1'b0;
            thr_valid_reg <= 1'b0;
            cls_valid_reg <= 1'b0;
            acc_sum_reg   <= '0;
            acc_cnt_reg   <= '0;
        end
        else if (adv)
        begin
            abs_valid_reg <= abs_valid_next;
            est_valid_reg <= est_valid_next;
            chk_valid_reg <= chk_valid_next;
            quo_valid_reg <= quo_valid_next;
            frm_valid_reg <= frm_valid_next;
            thr_valid_reg <= thr_valid_next;
            cls_valid_reg <= cls_valid_next;
            acc_sum_reg   <= acc_sum_next;
            acc_cnt_reg   <= acc_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            abs_mag_reg  <= abs_mag_next;
            abs_neg_reg  <= audio.sample[SAMPLE_W-1];
            abs_last_reg <= audio.last_in_frame;
            abs_time_reg <= audio.time_ms;

            est_mag_reg  <= abs_mag_reg;
            est_neg_reg  <= abs_neg_reg;
            est_last_reg <= abs_last_reg;
            est_time_reg <= abs_time_reg;
            est_q_reg    <= est_q_next;

            chk_mag_reg  <= est_mag_reg;
            chk_neg_reg  <= est_neg_reg;
            chk_last_reg <= est_last_reg;
            chk_time_reg <= est_time_reg;
            chk_q_reg    <= est_q_reg;
            chk_prod_reg <= chk_prod_next;

            quo_val_reg  <= quo_val_next;
            quo_last_reg <= chk_last_reg;
            quo_time_reg <= chk_time_reg;

            frm_sum_reg  <= sum_add;
            frm_cnt_reg  <= cnt_add;
            frm_time_reg <= quo_time_reg;

            thr_sum_reg  <= thr_sum_next;
            thr_hi_reg   <= thr_hi_next;
            thr_lo_reg   <= thr_lo_next;
            thr_time_reg <= frm_time_reg;

            cls_word_reg <= cls_word_next;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_cnt_reg <= CNT_W'(MAX_FRAME))
        else $error("frame count beyond frame limit");

    a_verdict_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cls_valid_reg && q_stat.full) |=> cls_valid_reg && $stable(cls_word_reg))
        else $error("pending verdict lost while queue full");
`endif

endmodule

FILE: design/fled_queue.sv
// Short verdict queue between the frame classifier and the event tracker.
module fled_queue import fled_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  fled_cls_t    push_word,
    input  logic         pop,
    output fled_cls_t    pop_word,
    output fled_q_stat_t stat
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    fled_cls_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign stat.full  = fill_reg == FILL_W'(DEPTH);
    assign stat.empty = fill_reg == '0;
    assign pop_word   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + FILL_W'(push) - FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");
`endif

endmodule

FILE: design/fled_back.sv
// Back end: attack and release tracking, event records into the output register.
module fled_back import fled_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fled_cfg_t    cfg,
    input  fled_q_stat_t q_stat,
    input  fled_cls_t    q_word,
    output logic         pop,
    fled_report_if.source report
);

    logic              in_event_reg, in_event_next;
    logic [TIME_W-1:0] event_start_reg, event_start_next;
    logic [7:0]        attack_left_reg, attack_left_next;
    logic [7:0]        release_left_reg, release_left_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_start_reg, out_start_next;
    logic [TIME_W-1:0] out_stamp_reg, out_dur_reg, out_dur_next;
    logic              emit;

    assign pop = !q_stat.empty && (!out_valid_reg || report.ready);

    assign report.valid       = out_valid_reg;
    assign report.is_start    = out_start_reg;
    assign report.stamp_ms    = out_stamp_reg;
    assign report.duration_ms = out_dur_reg;

    always_comb
    begin
        in_event_next     = in_event_reg;
        event_start_next  = event_start_reg;
        attack_left_next  = attack_left_reg;
        release_left_next = release_left_reg;
        emit              = 1'b0;
        out_start_next    = q_word.loud;
        out_dur_next      = '0;
        if (pop)
        begin
            if (q_word.loud)
            begin
                attack_left_next  = (attack_left_reg != '0) ? attack_left_reg - 1'b1 : '0;
                release_left_next = cfg.release_frames;
                if (!in_event_reg && attack_left_next == '0)
                begin
                    emit             = 1'b1;
                    in_event_next    = 1'b1;
                    event_start_next = q_word.time_ms;
                end
            end
            else
            begin
                attack_left_next  = cfg.attack_frames;
                release_left_next = (release_left_reg != '0) ? release_left_reg - 1'b1 : '0;
                if (in_event_reg && release_left_next == '0)
                begin
                    emit          = 1'b1;
                    in_event_next = 1'b0;
                    out_dur_next  = q_word.time_ms - event_start_reg
                                    + TIME_W'(cfg.duration_bias);
                end
            end
        end
        out_valid_next = (out_valid_reg && !report.ready) || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_event_reg     <= 1'b0;
            event_start_reg  <= '0;
            attack_left_reg  <= CFG_RESET.attack_frames;
            release_left_reg <= CFG_RESET.release_frames;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_event_reg     <= in_event_next;
            event_start_reg  <= event_start_next;
            attack_left_reg  <= attack_left_next;
            release_left_reg <= release_left_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_start_reg <= out_start_next;
            out_stamp_reg <= q_word.time_ms;
            out_dur_reg   <= out_dur_next;
        end
    end

`ifndef SYNTH
    a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && q_word.loud) |=> in_event_reg && out_valid_reg && out_start_reg)
        else $error("start record without entering event");

    a_release_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_word.loud) |=> release_left_reg == $past(cfg.release_frames))
        else $error("release counter not reloaded on loud frame");
`endif

endmodule

FILE: design/frame_level_event_detector_unit.sv
// Top level of the frame level event detector: register bank, front, queue and back.
//
//  channel  | role   | word
//  ---------+--------+---------------------------------------------
//  audio    | sink   | sample, last_in_frame, time_ms
//  report   | source | is_start, stamp_ms, duration_ms
//  cfg_*    | write  | cfg_index selects register, cfg_data value
//
// One sample per cycle while the front is not held by a full queue; the front
// pipeline is seven stages deep: abs, est, chk, quo, frm, thr and cls.
// The tracker retires one verdict per cycle unless a record in its single output
// register waits on report. A four-deep verdict queue absorbs stalls on report; once
// it is full and a further verdict waits, audio.ready drops.
// Reset is asynchronous, active low, and takes effect at once; no clearing pass.
module frame_level_event_detector_unit import fled_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int Q_DEPTH   = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fled_audio_if.sink            audio,
    fled_report_if.source         report
);

    fled_cfg_t    cfg_reg, cfg_next;
    logic         push, pop;
    fled_cls_t    push_word, pop_word;
    fled_q_stat_t q_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (fled_reg_t'(cfg_index))
                REG_ENABLE:         cfg_next.enable         = cfg_data[0];
                REG_LOUD_HIGH:      cfg_next.loud_high      = cfg_data[14:0];
                REG_LOUD_LOW:       cfg_next.loud_low       = $signed(cfg_data[15:0]);
                REG_ATTACK_FRAMES:  cfg_next.attack_frames  = cfg_data[7:0];
                REG_RELEASE_FRAMES: cfg_next.release_frames = cfg_data[7:0];
                REG_DURATION_BIAS:  cfg_next.duration_bias  = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fled_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .audio     (audio),
        .push      (push),
        .push_word (push_word),
        .q_stat    (q_stat)
    );

    fled_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .stat      (q_stat)
    );

    fled_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_word (pop_word),
        .pop    (pop),
        .report (report)
    );

endmodule
